FILE: hdl/pid_pkg.sv
// ----------------------------------------------------------------------------
// pid_pkg
// Shared widths, register indexes and helpers for the fixed-point PID step.
// ----------------------------------------------------------------------------
package pid_pkg;

  localparam int unsigned DataW    = 16;
  localparam int unsigned ErrW     = 17;
  localparam int unsigned IntegW   = 32;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned MulAW    = 36;
  localparam int unsigned MulBW    = 18;
  localparam int unsigned ProdW    = MulAW + MulBW;
  localparam int unsigned DivNumW  = 33;
  localparam int unsigned DivCntW  = 6;

  typedef enum logic [CfgAddrW-1:0] {
    REG_MODE_SELECT      = 3'd0,
    REG_GAIN_PROP        = 3'd1,
    REG_GAIN_INTEG       = 3'd2,
    REG_GAIN_DERIV       = 3'd3,
    REG_INTEGRAL_BOUNDS  = 3'd4,
    REG_OUTPUT_BOUNDS    = 3'd5,
    REG_OUTPUT_SHAPING   = 3'd6,
    REG_INTEGRAL_SHAPING = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    IMODE_OFF  = 2'd0,
    IMODE_NORM = 2'd1,
    IMODE_NONL = 2'd2,
    IMODE_SEP  = 2'd3
  } imode_e;

  typedef enum logic [1:0] {
    DMODE_OFF  = 2'd0,
    DMODE_ERR  = 2'd1,
    DMODE_MEAS = 2'd2,
    DMODE_FILT = 2'd3
  } dmode_e;

  // saturate to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [51:0] x);
    logic signed [51:0] hi;
    logic signed [51:0] lo;
    hi = 52'sh7FFFFFFF;
    lo = -52'sh80000000;
    if (x > hi) begin
      return 32'sh7FFFFFFF;
    end else if (x < lo) begin
      return 32'sh80000000;
    end else begin
      return x[31:0];
    end
  endfunction

endpackage

FILE: hdl/pid_controller_step_unit.sv
// ----------------------------------------------------------------------------
// pid_controller_step_unit
// Positional PID step: one shared multiplier and a restoring divider under a
// small sequencer turn each (setpoint, measured) word into one drive word.
// ----------------------------------------------------------------------------
// sequencing: each accepted word walks every product through the single
//   multiplier, and in nonlinear integral mode with a nonzero integral gain
//   through the bit-serial divider; the filtered derivative adds a step.
//   A new word is accepted only in the idle state, after the previous drive
//   word has been loaded into the output register, so a held output stalls it.
// reset: asynchronous, clears registers, history and integral to zero
module pid_controller_step_unit
  import pid_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [31:0]         s_axis_tdata,   // setpoint[15:0], measured[31:16]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [15:0]         m_axis_tdata    // drive[15:0]
);

  typedef enum logic [3:0] {
    S_IDLE, S_PM, S_NM, S_DI, S_DV, S_IU, S_IM, S_DM, S_DF, S_DG, S_SU, S_OUT
  } state_e;

  state_e state_q;

  logic [4:0]  mode_q;
  logic signed [15:0] kp_q, ki_q, kd_q;
  logic [63:0] ibnd_q;
  logic [31:0] obnd_q, oshp_q;
  logic [47:0] ishp_q;

  logic signed [ErrW-1:0]   last_err_q, e_q;
  logic signed [DataW-1:0]  last_ms_q;
  logic signed [IntegW-1:0] isum_q;
  logic signed [31:0]       deriv_q;
  logic signed [17:0]       de_q, dm_q;
  logic signed [32:0]       pterm_q;
  logic signed [39:0]       iterm_q;
  logic signed [33:0]       p1_q;
  logic signed [ProdW-1:0]  prod_q;
  logic [DivNumW-1:0]       quo_q, den_q;
  logic [DivNumW:0]         rem_q;
  logic [DivCntW-1:0]       cnt_q;
  logic [15:0]              res_q;
  logic                     ov_q;
  logic [15:0]              odata_q;

  imode_e imode;
  dmode_e dmode;
  logic signed [ErrW-1:0]  sp_e, ms_e, e_in;
  logic [ErrW-1:0]         abs_e;
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic [DivNumW:0]        rem_sh;
  logic                    div_ge;
  logic signed [33:0]      integ, inc, imax, imin;
  logic signed [34:0]      fdiff;
  logic signed [51:0]      fsum;
  logic signed [42:0]      sum_a, sum_b, omax, omin, offs, sum_t;
  logic                    accept;

  assign imode = imode_e'(mode_q[2:1]);
  assign dmode = dmode_e'(mode_q[4:3]);
  assign sp_e  = ErrW'($signed(s_axis_tdata[15:0]));
  assign ms_e  = ErrW'($signed(s_axis_tdata[31:16]));
  assign e_in  = sp_e - ms_e;
  assign abs_e = e_q[ErrW-1] ? ErrW'(-e_q) : e_q;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = odata_q;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    fdiff = 35'(deriv_q) - 35'($signed(prod_q[33:0]));
    case (state_q)
      S_PM: begin mul_a = MulAW'(e_q);           mul_b = MulBW'(kp_q); end
      S_NM: begin mul_a = MulAW'({1'b0, abs_e}); mul_b = MulBW'({2'b0, ishp_q[47:32]}); end
      S_IM: begin mul_a = MulAW'(isum_q);        mul_b = MulBW'(ki_q); end
      S_DM: begin
        mul_a = (dmode == DMODE_MEAS) ? MulAW'(dm_q) : MulAW'(de_q);
        mul_b = MulBW'(kd_q);
      end
      S_DF: begin mul_a = MulAW'(fdiff);         mul_b = MulBW'({2'b0, ishp_q[15:0]}); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign rem_sh = {rem_q[DivNumW-1:0], quo_q[DivNumW-1]};
  assign div_ge = rem_sh >= {1'b0, den_q};

  // integral update
  always_comb begin
    imax = 34'($signed(ibnd_q[63:32]));
    imin = 34'($signed(ibnd_q[31:0]));
    case (imode)
      IMODE_NONL: inc = e_q[ErrW-1] ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
      default:    inc = 34'(e_q) <<< 8;
    endcase
    integ = 34'(isum_q) + inc;
    if (imode == IMODE_OFF || ki_q == 16'sd0) begin
      integ = '0;
    end else if (imode == IMODE_SEP && abs_e > {1'b0, ishp_q[31:16]}) begin
      integ = '0;
    end
    if (integ > imax) integ = imax;
    if (integ < imin) integ = imin;
  end

  assign fsum = (52'(p1_q) <<< 16) + 52'($signed(prod_q[50:0]));

  // output sum
  always_comb begin
    omax  = 43'($signed(obnd_q[31:16])) <<< 8;
    omin  = 43'($signed(obnd_q[15:0])) <<< 8;
    offs  = 43'({oshp_q[31:16], 8'b0});
    sum_a = 43'(pterm_q) + 43'(iterm_q) + 43'(deriv_q);
    if (sum_a > 43'sd0) sum_b = sum_a + offs;
    else if (sum_a < 43'sd0) sum_b = sum_a - offs;
    else sum_b = sum_a;
    if (sum_b > omax) sum_b = omax;
    if (sum_b < omin) sum_b = omin;
    sum_t = sum_b[42] ? ((sum_b + 43'sd255) >>> 8) : (sum_b >>> 8);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      mode_q     <= '0;
      kp_q       <= '0;
      ki_q       <= '0;
      kd_q       <= '0;
      ibnd_q     <= '0;
      obnd_q     <= '0;
      oshp_q     <= '0;
      ishp_q     <= '0;
      last_err_q <= '0;
      last_ms_q  <= '0;
      isum_q     <= '0;
      deriv_q    <= '0;
      ov_q       <= 1'b0;
      cnt_q      <= '0;
      e_q        <= '0;
      de_q       <= '0;
      dm_q       <= '0;
      pterm_q    <= '0;
      iterm_q    <= '0;
      p1_q       <= '0;
      prod_q     <= '0;
      quo_q      <= '0;
      den_q      <= '0;
      rem_q      <= '0;
      res_q      <= '0;
      odata_q    <= '0;
    end else begin
      prod_q <= ProdW'(mul_a) * ProdW'(mul_b);
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_addr_i))
          REG_MODE_SELECT:      mode_q <= cfg_wdata_i[4:0];
          REG_GAIN_PROP:        kp_q   <= cfg_wdata_i[15:0];
          REG_GAIN_INTEG:       ki_q   <= cfg_wdata_i[15:0];
          REG_GAIN_DERIV:       kd_q   <= cfg_wdata_i[15:0];
          REG_INTEGRAL_BOUNDS:  ibnd_q <= cfg_wdata_i;
          REG_OUTPUT_BOUNDS:    obnd_q <= cfg_wdata_i[31:0];
          REG_OUTPUT_SHAPING:   oshp_q <= cfg_wdata_i[31:0];
          REG_INTEGRAL_SHAPING: ishp_q <= cfg_wdata_i[47:0];
          default: ;
        endcase
      end
      if (ov_q && m_axis_tready && state_q != S_OUT) ov_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            e_q        <= e_in;
            de_q       <= 18'(e_in) - 18'(last_err_q);
            dm_q       <= 18'(last_ms_q) - 18'($signed(s_axis_tdata[31:16]));
            last_err_q <= e_in;
            last_ms_q  <= s_axis_tdata[31:16];
            state_q    <= S_PM;
          end
        end
        S_PM: state_q <= S_NM;
        S_NM: begin
          pterm_q <= mode_q[0] ? prod_q[32:0] : '0;
          state_q <= S_DI;
        end
        S_DI: begin
          if (imode == IMODE_NONL && ki_q != 16'sd0) begin
            den_q   <= prod_q[DivNumW-1:0] + DivNumW'(256);
            rem_q   <= '0;
            quo_q   <= {abs_e, 16'b0};
            cnt_q   <= DivCntW'(DivNumW);
            state_q <= S_DV;
          end else begin
            state_q <= S_IU;
          end
        end
        S_DV: begin
          rem_q   <= div_ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
          quo_q   <= {quo_q[DivNumW-2:0], div_ge};
          cnt_q   <= cnt_q - 1'b1;
          if (cnt_q == DivCntW'(1)) state_q <= S_IU;
        end
        S_IU: begin
          isum_q  <= integ[IntegW-1:0];
          state_q <= S_IM;
        end
        S_IM: state_q <= S_DM;
        S_DM: begin
          iterm_q <= prod_q[47:8];
          state_q <= S_DF;
        end
        S_DF: begin
          p1_q <= prod_q[33:0];
          if (dmode == DMODE_OFF || kd_q == 16'sd0) begin
            deriv_q <= '0;
            state_q <= S_SU;
          end else if (dmode == DMODE_FILT) begin
            state_q <= S_DG;
          end else begin
            deriv_q <= sat32(52'($signed(prod_q[33:0])));
            state_q <= S_SU;
          end
        end
        S_DG: begin
          deriv_q <= sat32(fsum >>> 16);
          state_q <= S_SU;
        end
        S_SU: begin
          res_q   <= (abs_e < {1'b0, oshp_q[15:0]}) ? 16'd0 : sum_t[15:0];
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!ov_q || m_axis_tready) begin
            odata_q <= res_q;
            ov_q    <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_div_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DV |-> cnt_q != '0)
    else $error("divider running with empty count");

  a_isum_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IM |-> (isum_q <= $signed(ibnd_q[63:32]) || isum_q == $signed(ibnd_q[31:0])))
    else $error("integral outside its bounds");

  a_quo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IU && imode == IMODE_NONL && ki_q != 16'sd0) |-> quo_q[DivNumW-1:25] == '0)
    else $error("nonlinear increment too large");

  a_deriv_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SU && (dmode == DMODE_OFF || kd_q == 16'sd0)) |-> deriv_q == '0)
    else $error("derivative term not cleared");

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives random and directed (setpoint, measured) words through the PID step
// across several register settings and checks each drive word against an
// in-bench fixed-point predictor.
// ----------------------------------------------------------------------------
module tb
  import pid_pkg::*;
;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [31:0]         s_axis_tdata = '0;  // setpoint[15:0], measured[31:16]
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [15:0]         m_axis_tdata;       // drive[15:0]

  pid_controller_step_unit uut (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // predictor copy of registers and state
  logic [4:0]  r_mode;
  logic signed [15:0] r_kp, r_ki, r_kd;
  logic [63:0] r_ibnd;
  logic [31:0] r_obnd, r_oshape;
  logic [47:0] r_ishape;
  longint p_last_err, p_last_meas, p_integ, p_deriv;

  logic [31:0] word_q[$];
  logic [15:0] drive_q[$];
  int errors = 0;
  longint cycles = 0;
  bit calm = 1'b0;
  bit hold = 1'b0;
  bit all_sent = 1'b0;

  function automatic longint floor_div256(longint x);
    return x >>> 8;
  endfunction

  function automatic logic [15:0] predict_drive(logic [31:0] w);
    longint sp, ms, e, e_prev, kp, ki, kd, imax, imin, omax, omin, offs, dz;
    longint coef, thr, filt, pt, it, s, ig, ae, a, b;
    logic [1:0] im, dm;
    sp = longint'($signed(w[15:0]));
    ms = longint'($signed(w[31:16]));
    e = sp - ms;
    ae = e < 0 ? -e : e;
    e_prev = p_last_err;
    kp = r_kp; ki = r_ki; kd = r_kd;
    im = r_mode[2:1]; dm = r_mode[4:3];
    imax = longint'($signed(r_ibnd[63:32]));
    imin = longint'($signed(r_ibnd[31:0]));
    omax = longint'($signed(r_obnd[31:16])) * 256;
    omin = longint'($signed(r_obnd[15:0])) * 256;
    offs = longint'(r_oshape[31:16]) * 256;
    dz = longint'(r_oshape[15:0]);
    coef = longint'(r_ishape[47:32]);
    thr = longint'(r_ishape[31:16]);
    filt = longint'(r_ishape[15:0]);
    pt = 0;
    ig = p_integ;
    p_last_err = e;
    if (r_mode[0]) pt = kp * e;
    if (im == IMODE_OFF || ki == 0) ig = 0;
    else if (im == IMODE_NORM) ig += e * 256;
    else if (im == IMODE_NONL) ig += (e * 65536) / (coef * ae + 256);
    else if (ae > thr) ig = 0;
    else ig += e * 256;
    if (ig > imax) ig = imax;
    if (ig < imin) ig = imin;
    p_integ = longint'($signed(ig[31:0]));
    it = floor_div256(ki * p_integ);
    if (dm == DMODE_OFF || kd == 0) p_deriv = 0;
    else begin
      if (dm == DMODE_ERR) s = kd * (e - e_prev);
      else if (dm == DMODE_MEAS) s = -kd * (ms - p_last_meas);
      else begin
        a = (65536 - filt) * kd * (e - e_prev);
        b = filt * p_deriv;
        s = (a + b) >>> 16;
      end
      if (s > 64'sd2147483647) s = 64'sd2147483647;
      if (s < -64'sd2147483648) s = -64'sd2147483648;
      p_deriv = s;
    end
    p_last_meas = ms;
    s = pt + it + p_deriv;
    if (s > 0) s += offs;
    else if (s < 0) s -= offs;
    if (s > omax) s = omax;
    if (s < omin) s = omin;
    s = s / 256;
    if (ae < dz) s = 0;
    return s[15:0];
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %0d want %0d", what, $signed(got), $signed(want));
    errors++;
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [63:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_MODE_SELECT:      r_mode = v[4:0];
      REG_GAIN_PROP:        r_kp = v[15:0];
      REG_GAIN_INTEG:       r_ki = v[15:0];
      REG_GAIN_DERIV:       r_kd = v[15:0];
      REG_INTEGRAL_BOUNDS:  r_ibnd = v;
      REG_OUTPUT_BOUNDS:    r_obnd = v[31:0];
      REG_OUTPUT_SHAPING:   r_oshape = v[31:0];
      default:              r_ishape = v[47:0];
    endcase
  endtask

  task automatic wait_idle();
    while (word_q.size() != 0 || drive_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_word(int span);
    logic [15:0] sp, ms;
    if (span == 0) return $urandom;
    sp = 16'($signed($urandom_range(2 * span)) - span);
    ms = 16'($signed($urandom_range(2 * span)) - span);
    return {ms, sp};
  endfunction

  task automatic push_words(int n, int span);
    repeat (n) word_q.push_back(rand_word(span));
  endtask

  task automatic random_setting();
    write_reg(REG_MODE_SELECT, $urandom_range(31));
    write_reg(REG_GAIN_PROP, ($urandom_range(3) == 0) ? 0 : $urandom);
    write_reg(REG_GAIN_INTEG, ($urandom_range(4) == 0) ? 0 : $urandom);
    write_reg(REG_GAIN_DERIV, ($urandom_range(4) == 0) ? 0 : $urandom);
    write_reg(REG_INTEGRAL_BOUNDS, {$urandom, $urandom});
    write_reg(REG_OUTPUT_BOUNDS, $urandom);
    write_reg(REG_OUTPUT_SHAPING, {16'($urandom_range(600)), 16'($urandom_range(40))});
    write_reg(REG_INTEGRAL_SHAPING,
              {16'($urandom), 16'($urandom_range(3000)), 16'($urandom)});
  endtask

  // driver
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni) begin
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (word_q.size() != 0 && !hold && (calm || $urandom_range(99) >= 7)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= word_q.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= calm || ($urandom_range(99) >= 7);
    end
  end

  // monitor and predictor
  logic [15:0] want;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) drive_q.push_back(predict_drive(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (drive_q.size() == 0) report_mismatch("unexpected drive", m_axis_tdata, 16'h0);
        else begin
          want = drive_q.pop_front();
          if (m_axis_tdata !== want) report_mismatch("drive", m_axis_tdata, want);
        end
      end
    end
  end

  initial begin
    r_mode = '0; r_kp = '0; r_ki = '0; r_kd = '0;
    r_ibnd = '0; r_obnd = '0; r_oshape = '0; r_ishape = '0;
    p_last_err = 0; p_last_meas = 0; p_integ = 0; p_deriv = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: all paths on, wide bounds
    write_reg(REG_MODE_SELECT, 5'b01011);
    write_reg(REG_GAIN_PROP, 16'sh0180);
    write_reg(REG_GAIN_INTEG, 16'sh0040);
    write_reg(REG_GAIN_DERIV, 16'sh0100);
    write_reg(REG_INTEGRAL_BOUNDS, {32'sh00100000, -32'sh00100000});
    write_reg(REG_OUTPUT_BOUNDS, {16'sh7fff, 16'sh8000});
    write_reg(REG_OUTPUT_SHAPING, {16'd5, 16'd0});
    write_reg(REG_INTEGRAL_SHAPING, {16'h0080, 16'd100, 16'h4000});
    word_q.push_back({16'h8000, 16'h7fff});
    word_q.push_back({16'h7fff, 16'h8000});
    word_q.push_back({16'h0000, 16'h0000});
    word_q.push_back({16'h0005, 16'h0005});
    word_q.push_back({16'hffff, 16'hffff});
    word_q.push_back({16'h0000, 16'h8000});
    wait_idle();
    // nonlinear integral, extreme gains, filtered derivative, deadzone, widest integral bounds
    write_reg(REG_MODE_SELECT, 5'b11101);
    write_reg(REG_GAIN_PROP, 16'sh7fff);
    write_reg(REG_GAIN_INTEG, 16'sh8000);
    write_reg(REG_GAIN_DERIV, 16'sh7fff);
    write_reg(REG_INTEGRAL_BOUNDS, {32'sh7fffffff, 32'sh80000000});
    write_reg(REG_OUTPUT_SHAPING, {16'hffff, 16'd20});
    write_reg(REG_INTEGRAL_SHAPING, {16'hffff, 16'hffff, 16'hffff});
    word_q.push_back({16'h8000, 16'h7fff});
    word_q.push_back({16'h7fff, 16'h8000});
    word_q.push_back({16'h0003, 16'h0000});
    word_q.push_back({16'h0000, 16'h0000});
    wait_idle();
    write_reg(REG_MODE_SELECT, 5'b10111);
    write_reg(REG_INTEGRAL_BOUNDS, {-32'sd5000, 32'sd5000});
    write_reg(REG_OUTPUT_BOUNDS, {16'sd100, 16'sd200});
    write_reg(REG_INTEGRAL_SHAPING, {16'h0000, 16'd50, 16'h0000});
    word_q.push_back({16'd0, 16'd40});
    word_q.push_back({16'd0, 16'd60});
    word_q.push_back({16'd0, -16'sd60});
    word_q.push_back({16'd0, 16'd7});
    wait_idle();
    // random phases
    for (int ph = 0; ph < 14; ph++) begin
      random_setting();
      calm = (ph == 5);
      push_words(50, (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 300 : 4000));
      if (ph == 9) begin
        while (word_q.size() > 25) @(posedge clk_i);
        hold = 1'b1;
        while (drive_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
        hold = 1'b0;
      end
      wait_idle();
    end
    all_sent = 1'b1;
  end

  initial begin
    wait (all_sent);
    repeat (100) @(posedge clk_i);
    if (drive_q.size() != 0) report_mismatch("missing drive", 16'h0, drive_q[0]);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    wait (cycles > 400000);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
